// ----- rtl/core/cmwc_pkg.sv -----
package cmwc_pkg;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam int WORD_W  = 32;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = WORD_W + MULT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CY_W    = SUM_W - WORD_W;
  localparam int CARRY_W = 19;

  localparam logic [WORD_W-1:0]  PHI             = 32'h9e3779b9;
  localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
  localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;
  localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hfffffffe;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SEED  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_WRITE = 6'b100000
  } state_t;

  typedef struct packed {
    logic seed_load;
    logic seed_step;
    logic draw_start;
    logic mul;
    logic sum;
    logic fix;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/cmwc_ram.sv -----
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/cmwc_ctrl.sv -----
module cmwc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              operation,
  input  cmwc_pkg::status_t status,
  output cmwc_pkg::cmd_t    cmd,
  output logic              in_stall
);
  import cmwc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_DRAW) begin
            cmd.draw_start = 1'b1;
            state_next     = ST_MUL;
          end else begin
            cmd.seed_load = 1'b1;
            state_next    = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (status.seed_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/cmwc_datapath.sv -----
module cmwc_datapath #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  cmwc_pkg::cmd_t    cmd,
  output cmwc_pkg::status_t status,
  input  logic [31:0]       seed_value,
  output logic [31:0]       random_word,
  output logic              out_valid,
  input  logic              out_stall
);
  import cmwc_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [ADDR_W-1:0]  table_index;
  logic [ADDR_W-1:0]  index_inc;
  logic [ADDR_W-1:0]  seed_cnt;
  logic [WORD_W-1:0]  seed_reg;
  logic [WORD_W-1:0]  r1, r2, r3;
  logic [WORD_W-1:0]  seed_word;
  logic [CARRY_W-1:0] carry;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   t_sum;
  logic [WORD_W:0]    x_sum;
  logic [WORD_W-1:0]  x_val;
  logic [WORD_W-1:0]  new_word;
  logic [CY_W-1:0]    cy;
  logic               ovf;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  assign index_inc = table_index + 1'b1;

  always_comb begin
    if (seed_cnt == '0) begin
      seed_word = seed_reg;
    end else if (seed_cnt == ADDR_W'(1) || seed_cnt == ADDR_W'(2)) begin
      seed_word = r1 + PHI;
    end else begin
      seed_word = r3 ^ r2 ^ PHI ^ WORD_W'(seed_cnt);
    end
  end

  assign cy       = t_sum[SUM_W-1:WORD_W];
  assign x_sum    = {1'b0, t_sum[WORD_W-1:0]} + (WORD_W+1)'(cy);
  assign ovf      = x_sum[WORD_W];
  assign new_word = COMPLEMENT_BASE - x_val;

  assign ram_we    = cmd.seed_step | cmd.write;
  assign ram_waddr = cmd.seed_step ? seed_cnt : table_index;
  assign ram_wdata = cmd.seed_step ? seed_word : new_word;

  assign status.seed_last = (seed_cnt == ADDR_W'(TABLE_DEPTH - 1));
  assign status.out_free  = !out_valid || !out_stall;

  cmwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.draw_start),
    .rd_addr (index_inc),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_index <= ADDR_W'(TABLE_DEPTH - 1);
      carry       <= CARRY_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.draw_start) begin
        table_index <= index_inc;
      end
      if (cmd.fix) begin
        carry <= CARRY_W'(cy) + CARRY_W'(ovf);
      end
      if (cmd.write) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      seed_reg <= seed_value;
      seed_cnt <= '0;
    end
    if (cmd.seed_step) begin
      r1       <= seed_word;
      r2       <= r1;
      r3       <= r2;
      seed_cnt <= seed_cnt + 1'b1;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(MULTIPLIER) * PROD_W'(ram_rdata);
    end
    if (cmd.sum) begin
      t_sum <= SUM_W'(prod) + SUM_W'(carry);
    end
    if (cmd.fix) begin
      x_val <= x_sum[WORD_W-1:0] + WORD_W'(ovf);
    end
    if (cmd.write) begin
      random_word <= new_word;
    end
  end

endmodule

// ----- rtl/core/cmwc4096_random_generator.sv -----
// Channel  Handshake            Payload
// in       in_valid / in_stall  operation, seed_value
// out      out_valid / out_stall random_word
//
// Draw: table read, multiply, carry add, overflow fix and write-back run in
// that order, each as its own controller step.
// Seed: one table word is written per cycle through the write port.
// One item is in work at a time; the next is taken once the controller is idle.
// A result held by out_stall waits in the output register; a following draw
// stalls at write-back until it is taken. Reset (rst, synchronous) sets
// carry and index; the table holds garbage until the first seed.
module cmwc4096_random_generator #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word
);
  import cmwc_pkg::*;

  cmd_t    ctrl_cmd;
  status_t dp_status;

  cmwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .status    (dp_status),
    .cmd       (ctrl_cmd),
    .in_stall  (in_stall)
  );

  cmwc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctrl_cmd),
    .status      (dp_status),
    .seed_value  (seed_value),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not make the block busy");

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl_cmd.write))
    else $error("result appeared without a draw write-back");

  a_no_write_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctrl_cmd.seed_step && ctrl_cmd.write))
    else $error("seed and draw write the table together");

  a_no_result_on_seed: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_SEED) |=> !ctrl_cmd.write)
    else $error("seed produced a write-back");
`endif

endmodule

// ----- tb/tb_cmwc4096_random_generator.sv -----
module tb_cmwc4096_random_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import cmwc_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int N_RANDOM = 1580;
  localparam int IDLE_LIMIT = 40000;
  localparam int TAIL_CYCLES = 4200;

  localparam logic [1:0] STALL_NONE = 2'd0;
  localparam logic [1:0] STALL_LIGHT = 2'd1;
  localparam logic [1:0] STALL_HEAVY = 2'd2;
  localparam logic [1:0] STALL_PERIODIC = 2'd3;

  typedef struct {
    logic        op;
    logic [31:0] seed;
  } gen_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_SEED;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] random_word;

  gen_item_t   pending_items[$];
  logic [31:0] expected_words[$];
  int          n_items = 0;
  int          n_accepted = 0;
  int          n_errors = 0;
  int          idle_cycles = 0;

  // generator model state
  logic [31:0] lag_words[TABLE_DEPTH];
  logic [18:0] gen_carry = CARRY_RESET;
  logic [11:0] gen_index = 12'hfff;

  int          burst_left = 1;
  int          gap_left = 0;
  logic [1:0]  stall_mode = STALL_NONE;
  int          mode_left = 100;

  cmwc4096_random_generator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .seed_value (seed_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .random_word(random_word)
  );

  task automatic fill_lag_table(input logic [31:0] s);
    lag_words[0] = s;
    lag_words[1] = s + PHI;
    lag_words[2] = s + PHI + PHI;
    for (int k = 3; k < TABLE_DEPTH; k++) begin
      lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ PHI ^ 32'(k);
    end
  endtask

  task automatic draw_next_word(output logic [31:0] word);
    logic [63:0] t;
    logic [31:0] x;
    logic [31:0] cy;
    gen_index = gen_index + 12'd1;
    t = 64'(MULTIPLIER) * 64'(lag_words[gen_index]) + 64'(gen_carry);
    cy = t[63:32];
    x = t[31:0] + cy;
    if (x < cy) begin
      x = x + 32'd1;
      cy = cy + 32'd1;
    end
    gen_carry = cy[18:0];
    lag_words[gen_index] = COMPLEMENT_BASE - x;
    word = lag_words[gen_index];
  endtask

  task automatic add_item(input logic op, input logic [31:0] s);
    pending_items.push_back('{op, s});
    n_items++;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin : drive
    gen_item_t   item;
    logic [31:0] word;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        n_accepted++;
        if (operation == OP_DRAW) begin
          draw_next_word(word);
          expected_words.push_back(word);
        end else begin
          fill_lag_table(seed_value);
        end
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item = pending_items.pop_front();
          in_valid <= 1'b1;
          operation <= item.op;
          seed_value <= item.seed;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            case ($urandom_range(0, 7))
              0, 1: gap_left <= 0;
              7: gap_left <= $urandom_range(10, 40);
              default: gap_left <= $urandom_range(1, 4);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall behavior switches between modes
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left <= 100;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (mode_left[3:2] == 2'b11);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("random_word: unexpected item, actual %h", random_word);
        n_errors++;
      end else begin
        want = expected_words.pop_front();
        if (random_word !== want) begin
          $error("random_word: expected %h, actual %h", want, random_word);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [63:0] t0;
    logic [63:0] t;
    logic [63:0] s;
    logic [31:0] fix_seed;
    bit          found;
    found = 1'b0;
    fix_seed = '0;
    // seed whose first draw (entry 0, reset carry) overflows low word + carry
    for (int h = 18781; h > 0 && !found; h--) begin
      t0 = {32'(h), 32'h0} + 64'h1_0000_0000 - 64'(h);
      t = t0 + (64'(CARRY_RESET) % 64'(MULTIPLIER) + 64'(MULTIPLIER)
                - t0 % 64'(MULTIPLIER)) % 64'(MULTIPLIER);
      if (t[63:32] == 32'(h)) begin
        s = (t - 64'(CARRY_RESET)) / 64'(MULTIPLIER);
        fix_seed = s[31:0];
        found = 1'b1;
      end
    end

    add_item(OP_SEED, fix_seed);
    add_item(OP_DRAW, $urandom());
    add_item(OP_DRAW, 32'hffffffff);
    add_item(OP_DRAW, 32'h0);
    add_item(OP_DRAW, $urandom());
    add_item(OP_SEED, 32'h0);
    add_item(OP_DRAW, $urandom());
    add_item(OP_DRAW, $urandom());
    add_item(OP_DRAW, $urandom());
    add_item(OP_SEED, 32'hffffffff);
    add_item(OP_DRAW, 32'hffffffff);
    add_item(OP_DRAW, $urandom());
    add_item(OP_DRAW, $urandom());
    // back-to-back seeding
    add_item(OP_SEED, $urandom());
    add_item(OP_SEED, $urandom());
    add_item(OP_DRAW, $urandom());
    add_item(OP_DRAW, $urandom());
    add_item(OP_SEED, 32'haaaaaaaa);
    add_item(OP_DRAW, 32'h55555555);
    add_item(OP_DRAW, $urandom());

    for (int i = 0; i < N_RANDOM; i++) begin
      add_item(($urandom_range(0, 99) < 2) ? OP_SEED : OP_DRAW, $urandom());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted != n_items) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
